@@ rtl/dft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_pkg
// Types, character codes and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package dft_pkg;

    // Event codes on the result channel
    typedef enum logic [3:0] {
        EV_OPEN_ARRAY    = 4'd0,
        EV_CLOSE_ARRAY   = 4'd1,
        EV_OPEN_DICT     = 4'd2,
        EV_CLOSE_DICT    = 4'd3,
        EV_STRING_CHAR   = 4'd4,
        EV_STRING_END    = 4'd5,
        EV_KEY_CHAR      = 4'd6,
        EV_KEY_END       = 4'd7,
        EV_END_OF_STREAM = 4'd8,
        EV_ERROR         = 4'd9
    } ev_kind_t;

    // Lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_KEY    = 4'b0010,
        MODE_STRING = 4'b0100,
        MODE_ESCAPE = 4'b1000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        ev_kind_t   event_kind;
        logic [7:0] char_out;
        logic       last_event;
    } out_item_t;

    // Lexer outputs for one input byte
    typedef struct packed {
        lex_mode_t  mode;
        logic       quote_dbl;
        logic [1:0] ev_cnt;
        out_item_t  ev0;
        out_item_t  ev1;
    } lex_res_t;

    // Result of handling one byte between tokens
    typedef struct packed {
        logic      has_ev;
        out_item_t ev;
        lex_mode_t mode;
        logic      set_quote;
        logic      quote_dbl;
    } idle_res_t;

    // Result queue depth; a power of two so the pointers wrap on their own
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic may_be_key(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_DASH, CH_USCORE});
    endfunction

    function automatic out_item_t mk_ev(input ev_kind_t k, input logic [7:0] ch);
        out_item_t e;
        e.event_kind = k;
        e.char_out   = ch;
        e.last_event = 1'b0;
        return e;
    endfunction

    function automatic idle_res_t idle_step(input logic [7:0] c, input logic eoi);
        idle_res_t r;
        r.has_ev    = 1'b1;
        r.ev        = mk_ev(EV_ERROR, 8'd0);
        r.mode      = MODE_IDLE;
        r.set_quote = 1'b0;
        r.quote_dbl = 1'b0;
        if (eoi) begin
            r.ev = mk_ev(EV_END_OF_STREAM, 8'd0);
        end else if (c inside {CH_TAB, CH_LF, CH_CR, CH_VT, CH_SPACE}) begin
            r.has_ev = 1'b0;
        end else if (c == CH_LBRACK) begin
            r.ev = mk_ev(EV_OPEN_ARRAY, 8'd0);
        end else if (c == CH_RBRACK) begin
            r.ev = mk_ev(EV_CLOSE_ARRAY, 8'd0);
        end else if (c == CH_LBRACE) begin
            r.ev = mk_ev(EV_OPEN_DICT, 8'd0);
        end else if (c == CH_RBRACE) begin
            r.ev = mk_ev(EV_CLOSE_DICT, 8'd0);
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r.has_ev    = 1'b0;
            r.mode      = MODE_STRING;
            r.set_quote = 1'b1;
            r.quote_dbl = (c == CH_DQUOTE);
        end else if (may_be_key(c)) begin
            r.ev   = mk_ev(EV_KEY_CHAR, c);
            r.mode = MODE_KEY;
        end
        return r;
    endfunction

endpackage

@@ rtl/dft_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_lexer
// Next-state and event logic for one input byte: up to two events.
// ----------------------------------------------------------------------------
module dft_lexer
    import dft_pkg::*;
(
    input  lex_mode_t mode,
    input  logic      quote_dbl,
    input  in_item_t  item,
    output lex_res_t  res
);

    idle_res_t  idle;
    logic [7:0] c;
    logic       eoi;
    logic [7:0] quote_ch;
    logic [7:0] esc_ch;

    assign c        = item.byte_in;
    assign eoi      = item.end_of_input;
    assign quote_ch = quote_dbl ? CH_DQUOTE : CH_SQUOTE;
    assign idle     = idle_step(c, eoi);

    always_comb begin
        case (c)
            CH_LOW_T: esc_ch = CH_TAB;
            CH_LOW_V: esc_ch = CH_VT;
            CH_LOW_N: esc_ch = CH_LF;
            default:  esc_ch = c;
        endcase
    end

    always_comb begin
        res.mode      = mode;
        res.quote_dbl = quote_dbl;
        res.ev_cnt    = 2'd0;
        res.ev0       = mk_ev(EV_ERROR, 8'd0);
        res.ev1       = mk_ev(EV_ERROR, 8'd0);
        case (mode)
            MODE_IDLE: begin
                res.mode   = idle.mode;
                res.ev_cnt = {1'b0, idle.has_ev};
                res.ev0    = idle.ev;
                if (idle.set_quote) begin
                    res.quote_dbl = idle.quote_dbl;
                end
            end
            MODE_KEY: begin
                if (!eoi && may_be_key(c)) begin
                    res.ev_cnt = 2'd1;
                    res.ev0    = mk_ev(EV_KEY_CHAR, c);
                end else begin
                    // key_end, then the terminating byte is handled as idle
                    res.ev0    = mk_ev(EV_KEY_END, 8'd0);
                    res.ev1    = idle.ev;
                    res.ev_cnt = idle.has_ev ? 2'd2 : 2'd1;
                    res.mode   = idle.mode;
                    if (idle.set_quote) begin
                        res.quote_dbl = idle.quote_dbl;
                    end
                end
            end
            MODE_STRING: begin
                if (eoi) begin
                    res.mode   = MODE_IDLE;
                    res.ev_cnt = 2'd1;
                end else if (c == CH_BSLASH) begin
                    res.mode = MODE_ESCAPE;
                end else if (c == quote_ch) begin
                    res.mode   = MODE_IDLE;
                    res.ev_cnt = 2'd1;
                    res.ev0    = mk_ev(EV_STRING_END, 8'd0);
                end else begin
                    res.ev_cnt = 2'd1;
                    res.ev0    = mk_ev(EV_STRING_CHAR, c);
                end
            end
            MODE_ESCAPE: begin
                res.ev_cnt = 2'd1;
                if (eoi) begin
                    res.mode = MODE_IDLE;
                end else begin
                    res.mode = MODE_STRING;
                    res.ev0  = mk_ev(EV_STRING_CHAR, esc_ch);
                end
            end
            default: begin
                res.mode = MODE_IDLE;
            end
        endcase
        // mark the final event of this byte
        if (res.ev_cnt == 2'd2) begin
            res.ev1.last_event = 1'b1;
        end else begin
            res.ev0.last_event = 1'b1;
        end
    end

endmodule

@@ rtl/data_format_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_format_tokenizer
// Byte-at-a-time tokenizer for a bracketed string/array/dict text format.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Carries
//  --------+-------------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data      | one byte or end-of-input mark
//  result  | m_valid, m_ready, m_data      | one token event per transfer
//
//  One input byte is taken per cycle while s_ready is high. The lexer state
//  updates in the same cycle, and its 0..2 events land in a 4-entry result
//  queue; the result port drains one event per cycle while m_ready is high,
//  so bytes that make two events (a key closed by a bracket, a bad byte or
//  the end mark) need two result transfers. s_ready is high while the queue
//  has room for two events. Reset (aresetn low, synchronous) empties the
//  queue and returns the lexer to idle between tokens. Stalls on m_ready
//  back up through s_ready.
module data_format_tokenizer
    import dft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,

    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Lexer state
    lex_mode_t  mode_reg, mode_next;
    logic       quote_reg, quote_next;

    // Result queue: entries, pointers and fill count
    out_item_t            q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, wr_next;
    logic [Q_PTR_W-1:0]   rd_reg, rd_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    lex_res_t   lex;
    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] push_n;

    dft_lexer u_lexer (
        .mode      (mode_reg),
        .quote_dbl (quote_reg),
        .item      (s_data),
        .res       (lex)
    );

    // Room for the worst case of two events is kept before taking a byte
    assign s_ready  = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = (cnt_reg != '0);
    assign out_xfer = m_valid && m_ready;
    assign m_data   = q_reg[rd_reg];
    assign push_n   = in_xfer ? lex.ev_cnt : 2'd0;

    always_comb begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        if (in_xfer) begin
            mode_next  = lex.mode;
            quote_next = lex.quote_dbl;
        end
        wr_next  = wr_reg + Q_PTR_W'(push_n);
        rd_next  = rd_reg + Q_PTR_W'(out_xfer);
        cnt_next = cnt_reg + Q_CNT_W'(push_n) - Q_CNT_W'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= 1'b0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_reg] <= lex.ev0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_reg + Q_PTR_W'(1)] <= lex.ev1;
        end
    end

endmodule

@@ rtl/dft_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module dft_checker
    import dft_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Only character events carry a character
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != EV_STRING_CHAR
            && m_data.event_kind != EV_KEY_CHAR |-> m_data.char_out == 8'd0)
        else $error("nonzero char on non-character event");

    // Key characters are legal key bytes
    a_key_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_KEY_CHAR |-> may_be_key(m_data.char_out))
        else $error("illegal key character");

    // A closing quote is always the only event of its byte
    a_str_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_STRING_END |-> m_data.last_event)
        else $error("string_end not last event");

endmodule

bind data_format_tokenizer dft_checker u_dft_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/token_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_event_checker
// Passive monitor for the tokenizer: predicts token events from each input
// transfer and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module token_event_checker
    import dft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,

    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,

    output int unsigned mismatch_count,
    output int unsigned pending_events,
    output int unsigned events_checked,
    output logic [9:0]  kinds_seen
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow lexer state
    lex_mode_t  cur_mode;
    logic       dq_string;

    out_item_t  expected_events[$];
    out_item_t  step_events[$];

    // letters, digits, dash, underscore
    function automatic logic key_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_USCORE;
    endfunction

    function automatic void add_event(input ev_kind_t k, input logic [7:0] ch);
        out_item_t ev;
        ev.event_kind = k;
        ev.char_out   = ch;
        ev.last_event = 1'b0;
        step_events.push_back(ev);
    endfunction

    function automatic void between_tokens(input logic [7:0] c, input logic eoi);
        if (eoi) begin
            add_event(EV_END_OF_STREAM, 8'h00);
        end else begin
            case (c)
                CH_TAB, CH_LF, CH_CR, CH_VT, CH_SPACE: ;
                CH_LBRACK: add_event(EV_OPEN_ARRAY, 8'h00);
                CH_RBRACK: add_event(EV_CLOSE_ARRAY, 8'h00);
                CH_LBRACE: add_event(EV_OPEN_DICT, 8'h00);
                CH_RBRACE: add_event(EV_CLOSE_DICT, 8'h00);
                CH_SQUOTE, CH_DQUOTE: begin
                    cur_mode  = MODE_STRING;
                    dq_string = (c == CH_DQUOTE);
                end
                default: begin
                    if (key_byte(c)) begin
                        cur_mode = MODE_KEY;
                        add_event(EV_KEY_CHAR, c);
                    end else begin
                        add_event(EV_ERROR, 8'h00);
                    end
                end
            endcase
        end
    endfunction

    function automatic void predict_transfer(input in_item_t it);
        logic [7:0] c;
        logic       eoi;
        logic [7:0] close_q;
        logic [7:0] decoded;
        out_item_t  ev;
        c       = it.byte_in;
        eoi     = it.end_of_input;
        close_q = dq_string ? CH_DQUOTE : CH_SQUOTE;
        step_events.delete();
        case (cur_mode)
            MODE_KEY: begin
                if (!eoi && key_byte(c)) begin
                    add_event(EV_KEY_CHAR, c);
                end else begin
                    // terminating byte is handled again between tokens
                    add_event(EV_KEY_END, 8'h00);
                    cur_mode = MODE_IDLE;
                    between_tokens(c, eoi);
                end
            end
            MODE_STRING: begin
                if (eoi) begin
                    cur_mode = MODE_IDLE;
                    add_event(EV_ERROR, 8'h00);
                end else if (c == CH_BSLASH) begin
                    cur_mode = MODE_ESCAPE;
                end else if (c == close_q) begin
                    cur_mode = MODE_IDLE;
                    add_event(EV_STRING_END, 8'h00);
                end else begin
                    add_event(EV_STRING_CHAR, c);
                end
            end
            MODE_ESCAPE: begin
                if (eoi) begin
                    cur_mode = MODE_IDLE;
                    add_event(EV_ERROR, 8'h00);
                end else begin
                    decoded = c;
                    if (c == CH_LOW_T)      decoded = CH_TAB;
                    else if (c == CH_LOW_V) decoded = CH_VT;
                    else if (c == CH_LOW_N) decoded = CH_LF;
                    cur_mode = MODE_STRING;
                    add_event(EV_STRING_CHAR, decoded);
                end
            end
            default: between_tokens(c, eoi);
        endcase
        foreach (step_events[i]) begin
            ev = step_events[i];
            ev.last_event = (i == step_events.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            cur_mode  = MODE_IDLE;
            dq_string = 1'b0;
            expected_events.delete();
            mismatch_count = 0;
            events_checked = 0;
            kinds_seen     = '0;
        end else begin
            // predict first: a result at this edge is always older than this input
            if (s_valid && s_ready)
                predict_transfer(s_data);
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected event kind=%0d char=%h last=%b",
                                 $realtime, m_data.event_kind, m_data.char_out,
                                 m_data.last_event);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_data.event_kind !== want.event_kind ||
                        m_data.char_out   !== want.char_out   ||
                        m_data.last_event !== want.last_event) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $write("%0t: event mismatch exp kind=%0d char=%h last=%b",
                                   $realtime, want.event_kind, want.char_out,
                                   want.last_event);
                            $display(" got kind=%0d char=%h last=%b",
                                     m_data.event_kind, m_data.char_out,
                                     m_data.last_event);
                        end
                        mismatch_count++;
                    end
                    events_checked++;
                    kinds_seen[want.event_kind] = 1'b1;
                end
            end
        end
        pending_events = expected_events.size();
    end

endmodule

@@ dv/data_format_tokenizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_format_tokenizer_test
// Drives bytes and end marks into the tokenizer: a directed opening that hits
// brackets, keys, strings, escapes and error paths, then random documents
// under four idle/stall mixes. The checker module does all comparisons.
// ----------------------------------------------------------------------------
module data_format_tokenizer_test
    import dft_pkg::*;
();

    localparam int unsigned ITEM_TARGET = 1300;   // input transfers over the random phases
    localparam int unsigned LONG_HOLD   = 300;    // receiver hold-off, in cycles
    localparam int unsigned HOLD_ITEMS  = 40;     // items offered during the hold-off

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    in_item_t    s_data       = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    out_item_t   m_data;

    int unsigned mismatch_count;
    int unsigned pending_events;
    int unsigned events_checked;
    logic [9:0]  kinds_seen;

    // Written only by the stimulus process; the stall and hold-off settings are read by the receiver process
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off_req   = 1'b0;

    int unsigned items_sent     = 0;
    int unsigned counted_items  = 0;

    data_format_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    token_event_checker event_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_events (pending_events),
        .events_checked (events_checked),
        .kinds_seen     (kinds_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block hangs; the limit is far above a clean run
    initial begin
        #(2_000_000);
        $display("Timeout: run did not finish, %0d events still expected", pending_events);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls per phase, plus one long hold-off counted here.
    // The hold starts on the rising edge of hold_off_req.
    initial begin : receiver
        int unsigned hold_left;
        logic        hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_seen)
                hold_left = LONG_HOLD;
            hold_seen = hold_off_req;
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One input transfer. Called at a falling edge, returns at a falling edge
    // with valid low; the next call may raise it again in the same step.
    task automatic send_item(input logic [7:0] b, input logic eoi, input bit counts);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge aclk);
        s_data.byte_in      = b;
        s_data.end_of_input = eoi;
        s_valid             = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        items_sent++;
        if (counts)
            counted_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0, 1'b1);
    endtask

    // end mark carries a random byte, which the block must ignore
    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] pick_key_char();
        case ($urandom_range(3))
            0:       return 8'h61 + 8'($urandom_range(25));   // a..z
            1:       return 8'h41 + 8'($urandom_range(25));   // A..Z
            2:       return 8'h30 + 8'($urandom_range(9));    // 0..9
            default: return $urandom_range(1) ? CH_DASH : CH_USCORE;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(4))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return CH_VT;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_bracket();
        case ($urandom_range(3))
            0:       return CH_LBRACK;
            1:       return CH_RBRACK;
            2:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // Quoted string with random body; mostly closed, sometimes cut by the end mark
    task automatic send_string();
        logic [7:0] q;
        logic [7:0] other_q;
        logic [7:0] b;
        int unsigned len;
        q       = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        other_q = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        len     = $urandom_range(10);
        send_byte(q);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(99) < 20) begin
                send_byte(CH_BSLASH);
                case ($urandom_range(5))
                    0:       send_byte(CH_LOW_T);
                    1:       send_byte(CH_LOW_V);
                    2:       send_byte(CH_LOW_N);
                    3:       send_byte(q);            // escaped closing quote stays inside
                    4:       send_byte(CH_BSLASH);
                    default: send_byte(8'($urandom_range(255)));
                endcase
            end else begin
                b = 8'($urandom_range(255));
                // keep the body from closing early or opening an escape by accident
                if (b == q || b == CH_BSLASH)
                    b = other_q;
                send_byte(b);
            end
        end
        case ($urandom_range(39))
            0: send_end();                            // unterminated string
            1: begin                                  // dangling backslash
                send_byte(CH_BSLASH);
                send_end();
            end
            default: send_byte(q);
        endcase
    endtask

    // One token of a random document; keys are closed by whatever follows
    task automatic send_token();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 20) begin
            send_byte(pick_bracket());
        end else if (pick < 35) begin
            len = $urandom_range(1, 3);
            repeat (len) send_item(pick_space(), 1'b0, 1'b0);
        end else if (pick < 55) begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(pick_key_char());
        end else if (pick < 80) begin
            send_string();
        end else if (pick < 92) begin
            send_byte(8'($urandom_range(255)));       // noise, often an error
        end else begin
            send_end();
        end
    endtask

    // Opening pass over every event kind and the listed corner cases
    task automatic run_directed();
        send_byte(CH_LBRACE);
        send_byte(CH_LBRACK);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item(CH_TAB, 1'b0, 1'b0);
        send_byte(8'h61);                             // key: a-_Z9
        send_byte(CH_DASH);
        send_byte(CH_USCORE);
        send_byte(8'h5A);
        send_byte(8'h39);
        send_byte(CH_RBRACK);                         // key_end then close_array
        send_byte(CH_DQUOTE);
        send_byte(CH_SQUOTE);                         // other quote is plain text
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_T);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_V);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_N);
        send_byte(CH_BSLASH);
        send_byte(CH_DQUOTE);                         // escaped quote stays in string
        send_byte(8'hFF);
        send_byte(CH_DQUOTE);
        send_byte(8'hFF);                             // bad byte between tokens
        send_byte(8'h00);
        send_byte(CH_RBRACE);
        send_byte(8'h6B);                             // key cut by end mark
        send_end();
        send_byte(CH_SQUOTE);
        send_byte(CH_BSLASH);
        send_end();                                   // end mark inside escape
        send_end();                                   // end mark between tokens
    endtask

    initial begin : stimulus
        int unsigned phase_target;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        run_directed();
        wait (pending_events == 0);
        @(negedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase

            // Back-pressure: receiver holds off while brackets keep coming,
            // so the result queue fills and s_ready drops.
            if (ph == 0) begin
                hold_off_req = 1'b1;
                for (int i = 0; i < HOLD_ITEMS; i++)
                    send_byte(pick_bracket());
                hold_off_req = 1'b0;
            end

            phase_target = items_sent + ITEM_TARGET / 4;
            while (items_sent < phase_target)
                send_token();

            // sender pauses until every predicted event has been seen
            wait (pending_events == 0);
            @(negedge aclk);
        end

        wait (pending_events == 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d input transfers (%0d non-whitespace), checked %0d events",
                 items_sent, counted_items, events_checked);
        $display("Event kinds seen %b; idle mixes none, sender, receiver, both, plus hold-off",
                 kinds_seen);
        if (mismatch_count == 0 && pending_events == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
